### rtl/smx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, widths, constants and the exponent table of the softmax block.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int MAX_LEN   = 64;
  localparam int AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SCORE_W   = 16;
  localparam int EXP_W     = 17;
  localparam int SUM_W     = 23;
  localparam int REM_W     = SUM_W + 1;
  localparam int PROB_W    = 16;
  localparam int QUO_W     = 17;
  localparam int T_W       = 17;
  localparam int PROD_W    = 31;
  localparam int STEP_W    = 5;

  // log2(e) in Q1.14
  localparam logic [14:0] LOG2E_Q14 = 15'd23637;
  // shifts of this size or more flush the exponential to zero
  localparam logic [8:0]  EXP_SH_LIMIT = 9'd17;
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(QUO_W - 1);

  typedef logic [255:0][EXP_W-1:0] exp_tab_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_in;
  } smx_in_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              last_out;
    logic              truncated;
  } smx_out_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EXP_RD,
    S_EXP_MUL,
    S_EXP_WR,
    S_DIV_RD,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_PUT
  } smx_state_t;

  // Q2.62 fixed point helpers, evaluated at elaboration only
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] sqrt_q62(input logic [63:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    logic [127:0] tgt;
    r   = '0;
    tgt = {64'd0, x} << 62;
    for (int b = 62; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= tgt) begin
        r = c;
      end
    end
    return r;
  endfunction

  // entry f holds round(65536 * 2^(-f/256)), entry zero is 65536
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t         tab;
    logic [7:0][63:0] root;
    logic [63:0]      x;
    logic [63:0]      v;
    root[7] = sqrt_q62(64'd1 << 61);
    for (int k = 6; k >= 0; k--) begin
      root[k] = sqrt_q62(root[k+1]);
    end
    for (int f = 0; f < 256; f++) begin
      x = 64'd1 << 62;
      for (int k = 0; k < 8; k++) begin
        if (((f >> k) & 1) != 0) begin
          x = mul_q62(x, root[k]);
        end
      end
      v = (x + (64'd1 << 45)) >> 46;
      tab[f] = v[EXP_W-1:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

### rtl/smx_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/softmax_normalize.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: scores are stored while loading; after the closing score, the exp pass
//   reads, multiplies and writes back each stored score, then the divide pass reads,
//   sets up, runs a 17-step restoring divide and loads the output for each result
// throughput: one vector at a time, bound by the bit-serial divider
// reset: rst_n synchronous; clears the sequencer, fill count, max, sum and flags;
//   the score and exp memories are not cleared, only entries written this vector are read
// ----------------------------------------------------------------------------
// softmax_normalize
// Fixed-point softmax over a vector of Q8.8 scores, probabilities in Q0.16.
// ----------------------------------------------------------------------------
module softmax_normalize
  import smx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire smx_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output smx_out_t     out_data
);

  smx_state_t                state_r, state_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic signed [SCORE_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [T_W-1:0]            t_r, t_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [QUO_W-1:0]          quo_r, quo_nxt;
  logic                      lsb_r, lsb_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  smx_out_t                  out_data_r, out_data_nxt;

  logic                      in_fire;
  logic                      room;
  logic                      idx_last;
  logic                      score_we;
  logic                      exp_we;
  logic [SCORE_W-1:0]        score_rdata;
  logic [EXP_W-1:0]          exp_rdata;
  logic [EXP_W-1:0]          e_val;
  logic [8:0]                e_sh;
  logic [SCORE_W:0]          diff;
  logic [PROD_W-1:0]         prod;
  logic [REM_W-1:0]          rem_sh;
  logic                      rem_ge;

  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign room      = (fill_r < CNT_W'(MAX_LEN));
  assign idx_last  = ((idx_r + CNT_W'(1)) == fill_r);
  assign score_we  = in_fire && room;
  assign exp_we    = (state_r == S_EXP_WR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  smx_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_data.score),
    .raddr (idx_r[AW-1:0]),
    .rdata (score_rdata)
  );

  smx_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LEN)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (e_val),
    .raddr (idx_r[AW-1:0]),
    .rdata (exp_rdata)
  );

  // max - score is never negative, so the low 16 bits carry it
  assign diff = {max_r[SCORE_W-1], max_r} - {score_rdata[SCORE_W-1], score_rdata};
  assign prod = {15'd0, diff[SCORE_W-1:0]} * {16'd0, LOG2E_Q14};

  assign e_sh  = t_r[T_W-1:8];
  assign e_val = (e_sh >= EXP_SH_LIMIT) ? '0 : (EXP_TAB[t_r[7:0]] >> e_sh[4:0]);

  // one restoring divide step, remainder stays below sum
  assign rem_sh = {rem_r[REM_W-2:0], lsb_r};
  assign rem_ge = (rem_sh >= {1'b0, sum_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      idx_r       <= '0;
      max_r       <= {1'b1, {(SCORE_W-1){1'b0}}};
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    lsb_r      <= lsb_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    step_nxt      = step_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    lsb_nxt       = lsb_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (room) begin
            fill_nxt = fill_r + CNT_W'(1);
            if (in_data.score > max_r) begin
              max_nxt = in_data.score;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_in) begin
            idx_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = S_EXP_RD;
          end
        end
      end
      S_EXP_RD: begin
        state_nxt = S_EXP_MUL;
      end
      S_EXP_MUL: begin
        t_nxt     = prod[PROD_W-1:14];
        state_nxt = S_EXP_WR;
      end
      S_EXP_WR: begin
        sum_nxt = sum_r + SUM_W'(e_val);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_DIV_RD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_EXP_RD;
        end
      end
      S_DIV_RD: begin
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        // dividend is e << 16: upper bits preload the remainder
        rem_nxt   = REM_W'(exp_rdata[EXP_W-1:1]);
        lsb_nxt   = exp_rdata[0];
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        rem_nxt  = rem_ge ? (rem_sh - {1'b0, sum_r}) : rem_sh;
        quo_nxt  = {quo_r[QUO_W-2:0], rem_ge};
        lsb_nxt  = 1'b0;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST_STEP) begin
          state_nxt = S_DIV_PUT;
        end
      end
      S_DIV_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.prob      = quo_r[QUO_W-1] ? '1 : quo_r[PROB_W-1:0];
          out_data_nxt.last_out  = idx_last;
          out_data_nxt.truncated = ovf_r;
          if (idx_last) begin
            fill_nxt  = '0;
            idx_nxt   = '0;
            max_nxt   = {1'b1, {(SCORE_W-1){1'b0}}};
            sum_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_DIV_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

### bench/softmax_normalize_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_normalize_test
// Drives score vectors into the softmax block. A short table covers the
// extremes, and random vectors of varied length and spread follow, some
// longer than the store. Every probability is compared with a fixed-point
// softmax computed alongside or, for typed rows, with the table's values.
// ----------------------------------------------------------------------------
module softmax_normalize_test
  import smx_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 440;
  localparam int DIR_ROWS    = 19;
  localparam int CALM_ITEMS  = 60;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    bit                        last;
    bit                        typed;
    logic [PROB_W-1:0]         p0;
    logic [PROB_W-1:0]         p1;
  } plan_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  smx_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  smx_out_t out_data;

  softmax_normalize dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2^(-f/256) in Q1.16, rounded to nearest
  logic [EXP_W-1:0] pow2_frac [256];

  // vector being collected
  int       vec_scores [$];
  int       vec_peak;
  bit       vec_dropped;
  smx_out_t vec_probs [$];

  smx_out_t prob_expect_q [$];

  plan_row_t plan [DIR_ROWS];

  int  err_count;
  int  cycles;
  int  probs_seen;
  int  trunc_vectors;
  int  vectors_sent;
  int  items_sent;
  int  gap_odds;
  int  stall_left;
  bit  calm;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               prob_expect_q.size());
      $display("softmax_normalize_test: FAIL");
      $finish;
    end
  end

  // result side stalls in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    smx_out_t want;
    if (rst_n && out_valid && out_ready) begin
      probs_seen = probs_seen + 1;
      if (out_data.truncated && out_data.last_out) begin
        trunc_vectors = trunc_vectors + 1;
      end
      if (prob_expect_q.size() == 0) begin
        $error("result transaction with nothing expected: prob %0d last_out %0b",
               out_data.prob, out_data.last_out);
        err_count = err_count + 1;
      end else begin
        want = prob_expect_q.pop_front();
        if (out_data.prob !== want.prob) begin
          $error("prob: expected %0d, actual %0d", want.prob, out_data.prob);
          err_count = err_count + 1;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %0b, actual %0b", want.last_out, out_data.last_out);
          err_count = err_count + 1;
        end
        if (out_data.truncated !== want.truncated) begin
          $error("truncated: expected %0b, actual %0b", want.truncated,
                 out_data.truncated);
          err_count = err_count + 1;
        end
      end
    end
  end

  // one accepted score; a closing score fills vec_probs with the softmax
  function automatic void absorb_score(smx_in_t item);
    logic [EXP_W-1:0] e_val [$];
    logic [SUM_W-1:0] e_sum;
    logic [63:0]      t;
    logic [63:0]      quo;
    logic [31:0]      nd;
    logic [EXP_W-1:0] base;
    smx_out_t         r;
    int               n;
    int               sh;
    if (vec_scores.size() < MAX_LEN) begin
      vec_scores.push_back(int'(item.score));
      if (int'(item.score) > vec_peak) begin
        vec_peak = int'(item.score);
      end
    end else begin
      vec_dropped = 1'b1;
    end
    vec_probs.delete();
    if (!item.last_in) begin
      return;
    end
    n     = vec_scores.size();
    e_sum = '0;
    for (int i = 0; i < n; i++) begin
      nd   = 32'(vec_peak - vec_scores[i]);
      t    = (64'(nd) * 64'(LOG2E_Q14)) >> 14;
      sh   = int'(t >> 8);
      base = (t[7:0] == 8'd0) ? EXP_W'(65536) : pow2_frac[t[7:0]];
      e_val.push_back((sh >= 17) ? '0 : (base >> sh));
      e_sum = e_sum + SUM_W'(e_val[i]);
    end
    for (int i = 0; i < n; i++) begin
      quo = 64'd0;
      if (e_sum != '0) begin
        quo = (64'(e_val[i]) << 16) / 64'(e_sum);
        if (quo > 64'd65535) begin
          quo = 64'd65535;
        end
      end
      r.prob      = quo[PROB_W-1:0];
      r.last_out  = (i == n - 1);
      r.truncated = vec_dropped;
      vec_probs.push_back(r);
    end
    vec_scores.delete();
    vec_peak    = -32768;
    vec_dropped = 1'b0;
  endfunction

  // called at a falling edge, returns at the next falling edge after the transaction
  task automatic send_score(input smx_in_t item, input bit typed,
                            input logic [PROB_W-1:0] p0, input logic [PROB_W-1:0] p1);
    smx_out_t r;
    int       n;
    if (!calm && gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent = items_sent + 1;
    absorb_score(item);
    n = vec_probs.size();
    if (item.last_in) begin
      vectors_sent = vectors_sent + 1;
    end
    for (int i = 0; i < n; i++) begin
      r = vec_probs[i];
      if (typed) begin
        r.prob = (i == 0) ? p0 : p1;
      end
      prob_expect_q.push_back(r);
    end
    @(negedge clk);
  endtask

  initial begin
    smx_in_t           item;
    int                len;
    int                mode;
    int                pick;
    int                vec_idx;
    int                rand_items;
    logic [SCORE_W-1:0] base;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    stall_left = 0;
    calm       = 1'b0;
    gap_odds   = 3;
    err_count  = 0;
    cycles     = 0;
    probs_seen = 0;
    trunc_vectors = 0;
    vectors_sent  = 0;
    items_sent    = 0;
    vec_peak    = -32768;
    vec_dropped = 1'b0;
    pow2_frac[0] = EXP_W'(65536);
    for (int f = 1; f < 256; f++) begin
      pow2_frac[f] = EXP_W'($rtoi(65536.0 * (2.0 ** (-f / 256.0)) + 0.5));
    end

    // typed rows: p0/p1 are the probabilities of the vector closed there
    plan = '{
      '{16'sh0000, 1'b1, 1'b1, 16'd65535, 16'd0},
      '{16'sh7FFF, 1'b1, 1'b1, 16'd65535, 16'd0},
      '{16'sh8000, 1'b1, 1'b1, 16'd65535, 16'd0},
      '{16'sh0000, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'sh0000, 1'b1, 1'b1, 16'd32768, 16'd32768},
      '{16'sh7FFF, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'sh8000, 1'b1, 1'b1, 16'd65535, 16'd0},
      '{16'sh8000, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'sh7FFF, 1'b1, 1'b1, 16'd0, 16'd65535},
      '{16'sh0100, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'sh0000, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'shFF00, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'sh0200, 1'b1, 1'b0, 16'd0, 16'd0},
      '{16'shFFFF, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'sh0001, 1'b1, 1'b0, 16'd0, 16'd0},
      '{16'sh5555, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'shAAAA, 1'b1, 1'b0, 16'd0, 16'd0},
      '{16'sh0000, 1'b0, 1'b0, 16'd0, 16'd0},
      '{16'shFFFF, 1'b1, 1'b0, 16'd0, 16'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      item.score   = plan[i].score;
      item.last_in = plan[i].last;
      send_score(item, plan[i].typed, plan[i].p0, plan[i].p1);
    end

    // hold the sender until the table has fully drained
    in_valid <= 1'b0;
    while (prob_expect_q.size() != 0) @(negedge clk);

    vec_idx    = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (vec_idx == 0) begin
        len = MAX_LEN;
      end else if (vec_idx == 1) begin
        len = MAX_LEN + 3;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) len = $urandom_range(1, 8);
        else if (pick < 85) len = $urandom_range(9, 24);
        else if (pick < 95) len = $urandom_range(25, MAX_LEN);
        else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
      end
      mode     = $urandom_range(0, 3);
      base     = SCORE_W'($urandom());
      gap_odds = $urandom_range(0, 4);
      calm     = (rand_items >= RAND_ITEMS - CALM_ITEMS);
      // mid-run, once let every outstanding probability come back first
      if (vec_idx == 12) begin
        in_valid <= 1'b0;
        while (prob_expect_q.size() != 0) @(negedge clk);
      end
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: item.score = SCORE_W'($urandom());
          1: item.score = base + SCORE_W'($urandom_range(0, 2047)) - SCORE_W'(1024);
          2: item.score = base;
          default: item.score = base + SCORE_W'($urandom_range(0, 15));
        endcase
        item.last_in = (k == len - 1);
        send_score(item, 1'b0, '0, '0);
      end
      rand_items = rand_items + len;
      vec_idx    = vec_idx + 1;
    end
    in_valid <= 1'b0;

    while (prob_expect_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d scores in %0d vectors, checked %0d probabilities", items_sent,
             vectors_sent, probs_seen);
    $display("%0d vectors overran the store and were flagged", trunc_vectors);
    if (err_count == 0) begin
      $display("softmax_normalize_test: PASS");
    end else begin
      $display("softmax_normalize_test: FAIL");
    end
    $finish;
  end

endmodule
